// File: hdl/fdl_pkg.sv
// shared constants, types and arithmetic helpers for the feedback delay line
`default_nettype none

package fdl_pkg;

  // sample and line geometry
  localparam int SampleBits   = 24;
  localparam int BufferDepth  = 4096;
  localparam int DelaySamples = 2400;
  localparam int AddrBits     = $clog2(BufferDepth);
  localparam int DelayOff     = DelaySamples % BufferDepth;

  // gains: targets Q0.16, smoothed values Q0.24
  localparam int GainBits   = 16;
  localparam int SmoothBits = 24;
  localparam int SmoothK    = 33554;
  localparam int FbMax      = 55705;
  localparam int FbReset    = 22938;
  localparam int MixReset   = 26214;

  // shared multiplier and accumulator widths
  localparam int OpBits   = 26;
  localparam int ProdBits = 2 * OpBits;
  localparam int AccBits  = ProdBits + 1;
  localparam int RndShift = 24;
  localparam int RndBits  = AccBits - RndShift;

  // register port
  localparam int NumRegs   = 2;
  localparam int PaddrBits = $clog2(NumRegs) + 2;
  localparam int PdataBits = 32;

  typedef enum logic [0:0] {
    REG_FEEDBACK = 1'b0,
    REG_MIX      = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_FB_SMOOTH  = 3'd0,
    MUL_MIX_SMOOTH = 3'd1,
    MUL_FEEDBACK   = 3'd2,
    MUL_DRY        = 3'd3,
    MUL_WET        = 3'd4
  } mul_op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_SMF  = 3'd1,
    ST_SMM  = 3'd2,
    ST_WET  = 3'd3,
    ST_WR   = 3'd4,
    ST_DRY  = 3'd5,
    ST_SUM  = 3'd6,
    ST_OUT  = 3'd7
  } fdl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    load_dry;
    mul_op_e mul_op;
    logic    upd_fb;
    logic    upd_mix;
    logic    write_wet;
    logic    load_acc;
    logic    add_acc;
    logic    load_out;
  } fdl_cmd_t;

  // divide by 2^24, round half away from zero
  function automatic logic signed [RndBits-1:0] rnd24(input logic signed [AccBits-1:0] v);
    logic signed [AccBits-1:0] bias;
    logic signed [AccBits-1:0] tmp;
    bias = v[AccBits-1] ? AccBits'(2 ** (RndShift - 1) - 1) : AccBits'(2 ** (RndShift - 1));
    tmp  = v + bias;
    return tmp[AccBits-1:RndShift];
  endfunction

  // clip to the signed sample range
  function automatic logic signed [SampleBits-1:0] sat_sample(
    input logic signed [RndBits-1:0] v
  );
    logic signed [RndBits-1:0] hi;
    logic signed [RndBits-1:0] lo;
    hi = RndBits'(2 ** (SampleBits - 1) - 1);
    lo = RndBits'(-(2 ** (SampleBits - 1)));
    if (v > hi) begin
      return hi[SampleBits-1:0];
    end else if (v < lo) begin
      return lo[SampleBits-1:0];
    end
    return v[SampleBits-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/fdl_regs.sv
// register port holding the feedback and mix gain targets
`default_nettype none

module fdl_regs
  import fdl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PaddrBits-1:0] paddr,
  input  wire logic [PdataBits-1:0] pwdata,
  output logic      [PdataBits-1:0] prdata,
  output logic                      pready,
  output logic      [GainBits-1:0]  fb_tgt_o,
  output logic      [GainBits-1:0]  mix_tgt_o
);

  logic [GainBits-1:0] fb_q, fb_d;
  logic [GainBits-1:0] mix_q, mix_d;
  logic [GainBits-1:0] wval;
  reg_idx_e            idx;
  logic                wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PaddrBits-1:2]);
  assign wr     = psel & penable & pwrite;
  assign wval   = pwdata[GainBits-1:0];

  // write decode, feedback target clipped to keep loop gain below one
  always_comb begin
    fb_d  = fb_q;
    mix_d = mix_q;
    if (wr) begin
      unique case (idx)
        REG_FEEDBACK: begin
          fb_d = (wval > GainBits'(FbMax)) ? GainBits'(FbMax) : wval;
        end
        REG_MIX: begin
          mix_d = wval;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q  <= GainBits'(FbReset);
      mix_q <= GainBits'(MixReset);
    end else begin
      fb_q  <= fb_d;
      mix_q <= mix_d;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_FEEDBACK: prdata = {{(PdataBits-GainBits){1'b0}}, fb_q};
      REG_MIX:      prdata = {{(PdataBits-GainBits){1'b0}}, mix_q};
      default:      prdata = '0;
    endcase
  end

  assign fb_tgt_o  = fb_q;
  assign mix_tgt_o = mix_q;

endmodule

`default_nettype wire

// File: hdl/fdl_ctrl.sv
// sequencer stepping one word through the shared multiplier
`default_nettype none

module fdl_ctrl
  import fdl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output fdl_cmd_t  cmd_o
);

  fdl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{load_dry: 1'b0, mul_op: MUL_FB_SMOOTH, upd_fb: 1'b0, upd_mix: 1'b0,
                write_wet: 1'b0, load_acc: 1'b0, add_acc: 1'b0, load_out: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_dry = 1'b1;
          state_d        = ST_SMF;
        end
      end
      ST_SMF: begin
        cmd_o.mul_op = MUL_FB_SMOOTH;
        state_d      = ST_SMM;
      end
      ST_SMM: begin
        cmd_o.upd_fb = 1'b1;
        cmd_o.mul_op = MUL_MIX_SMOOTH;
        state_d      = ST_WET;
      end
      ST_WET: begin
        cmd_o.upd_mix = 1'b1;
        cmd_o.mul_op  = MUL_FEEDBACK;
        state_d       = ST_WR;
      end
      ST_WR: begin
        cmd_o.write_wet = 1'b1;
        cmd_o.mul_op    = MUL_DRY;
        state_d         = ST_DRY;
      end
      ST_DRY: begin
        cmd_o.load_acc = 1'b1;
        cmd_o.mul_op   = MUL_WET;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.add_acc = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        // wait here until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output word valid flag
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/fdl_dpath.sv
// datapath: delay line memory, gain smoothing, shared multiplier, output register
`default_nettype none

module fdl_dpath
  import fdl_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fdl_cmd_t                      cmd_i,
  input  wire logic        [GainBits-1:0]    fb_tgt_i,
  input  wire logic        [GainBits-1:0]    mix_tgt_i,
  input  wire logic signed [SampleBits-1:0]  sample_in_i,
  output logic signed      [SampleBits-1:0]  sample_out_o
);

  // delay line storage, no reset; unwritten entries read as zero
  logic signed [SampleBits-1:0] line_mem [BufferDepth];

  logic        [AddrBits-1:0]   wp_q;
  logic                         wrapped_q;
  logic        [AddrBits-1:0]   rp;
  logic signed [SampleBits-1:0] rd_q;
  logic                         rd_valid_q;
  logic signed [SampleBits-1:0] dly;

  logic signed [SampleBits-1:0] dry_q;
  logic        [SmoothBits-1:0] fb_q;
  logic        [SmoothBits-1:0] mix_q;
  logic signed [ProdBits-1:0]   prod_q;
  logic signed [AccBits-1:0]    acc_q;
  logic signed [SampleBits-1:0] out_q;

  logic signed [OpBits-1:0]     a_op, b_op;
  logic signed [OpBits-1:0]     d_fb, d_mix;
  logic signed [OpBits-1:0]     fb_tgt_ext, mix_tgt_ext, fb_cur_ext, mix_cur_ext;
  logic        [SmoothBits:0]   one_minus_mix;
  logic signed [AccBits-1:0]    prod_ext;
  logic signed [RndBits-1:0]    prod_rnd;
  logic signed [RndBits-1:0]    fb_sum, mix_sum, fb_base, mix_base;
  logic signed [RndBits-1:0]    dry_ext, wet_sum;
  logic signed [SampleBits-1:0] wet;
  logic        [SmoothBits-1:0] fb_new, mix_new;

  // read address a fixed distance behind the write pointer
  always_comb begin
    if (wp_q >= AddrBits'(DelayOff)) begin
      rp = wp_q - AddrBits'(DelayOff);
    end else begin
      rp = wp_q + AddrBits'(BufferDepth - DelayOff);
    end
  end

  // memory read and write
  always_ff @(posedge clk_i) begin
    rd_q <= line_mem[rp];
    if (cmd_i.write_wet) begin
      line_mem[wp_q] <= wet;
    end
  end

  // entries below the write pointer are written until the first wrap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= wrapped_q | (rp < wp_q);
    end
  end

  assign dly = rd_valid_q ? rd_q : '0;

  // distance of each smoothed gain from its target
  assign fb_tgt_ext  = {2'b00, fb_tgt_i, 8'h00};
  assign mix_tgt_ext = {2'b00, mix_tgt_i, 8'h00};
  assign fb_cur_ext  = {{(OpBits-SmoothBits){1'b0}}, fb_q};
  assign mix_cur_ext = {{(OpBits-SmoothBits){1'b0}}, mix_q};
  assign d_fb        = fb_tgt_ext - fb_cur_ext;
  assign d_mix       = mix_tgt_ext - mix_cur_ext;
  assign one_minus_mix = (SmoothBits + 1)'(2 ** SmoothBits) - {1'b0, mix_q};

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_FB_SMOOTH: begin
        a_op = d_fb;
        b_op = OpBits'(SmoothK);
      end
      MUL_MIX_SMOOTH: begin
        a_op = d_mix;
        b_op = OpBits'(SmoothK);
      end
      MUL_FEEDBACK: begin
        a_op = {{(OpBits-SampleBits){dly[SampleBits-1]}}, dly};
        b_op = fb_cur_ext;
      end
      MUL_DRY: begin
        a_op = {{(OpBits-SampleBits){dry_q[SampleBits-1]}}, dry_q};
        b_op = {{(OpBits-SmoothBits-1){1'b0}}, one_minus_mix};
      end
      MUL_WET: begin
        a_op = {{(OpBits-SampleBits){dly[SampleBits-1]}}, dly};
        b_op = mix_cur_ext;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_op * b_op;
  end

  assign prod_ext = {prod_q[ProdBits-1], prod_q};
  assign prod_rnd = rnd24(prod_ext);

  // one-pole smoothing step, clipped to Q0.24
  assign fb_base  = {{(RndBits-SmoothBits){1'b0}}, fb_q};
  assign mix_base = {{(RndBits-SmoothBits){1'b0}}, mix_q};
  assign fb_sum   = fb_base + prod_rnd;
  assign mix_sum  = mix_base + prod_rnd;

  always_comb begin
    if (fb_sum < 0) begin
      fb_new = '0;
    end else if (fb_sum > RndBits'(2 ** SmoothBits - 1)) begin
      fb_new = '1;
    end else begin
      fb_new = fb_sum[SmoothBits-1:0];
    end
    if (mix_sum < 0) begin
      mix_new = '0;
    end else if (mix_sum > RndBits'(2 ** SmoothBits - 1)) begin
      mix_new = '1;
    end else begin
      mix_new = mix_sum[SmoothBits-1:0];
    end
  end

  // value fed back into the line
  assign dry_ext = {{(RndBits-SampleBits){dry_q[SampleBits-1]}}, dry_q};
  assign wet_sum = dry_ext + prod_rnd;
  assign wet     = sat_sample(wet_sum);

  // gain state and write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q      <= SmoothBits'(FbReset * 256);
      mix_q     <= SmoothBits'(MixReset * 256);
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else begin
      if (cmd_i.upd_fb) begin
        fb_q <= fb_new;
      end
      if (cmd_i.upd_mix) begin
        mix_q <= mix_new;
      end
      if (cmd_i.load_out) begin
        if (wp_q == AddrBits'(BufferDepth - 1)) begin
          wp_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wp_q <= wp_q + AddrBits'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_dry) begin
      dry_q <= sample_in_i;
    end
    if (cmd_i.load_acc) begin
      acc_q <= prod_ext;
    end else if (cmd_i.add_acc) begin
      acc_q <= acc_q + prod_ext;
    end
    if (cmd_i.load_out) begin
      out_q <= sat_sample(rnd24(acc_q));
    end
  end

  assign sample_out_o = out_q;

endmodule

`default_nettype wire

// File: hdl/feedback_delay_line.sv
// top level of the feedback delay echo
//
//   port group   direction  width  notes
//   in_*         input      24     dry sample word, valid/ready
//   out_*        output     24     blended sample word, valid/ready
//   apb          in/out     32     feedback_gain at 0x0, mix_gain at 0x4
//
// A word passes through the accept state and seven steps, during which one shared
// 26x26 multiplier forms five products in turn (two smoothing steps,
// the feedback product, the dry and wet mix products).
// The output register lets the next word enter while a result waits; a
// word that reaches its last step with the output still full holds there.
// Reset is asynchronous and active low; the delay line reads as zero until
// written, with no clearing pass.
`default_nettype none

module feedback_delay_line
  import fdl_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [SampleBits-1:0] sample_in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed      [SampleBits-1:0] sample_out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic        [PaddrBits-1:0]  paddr,
  input  wire logic        [PdataBits-1:0]  pwdata,
  output logic             [PdataBits-1:0]  prdata,
  output logic                              pready
);

  fdl_cmd_t            cmd;
  logic [GainBits-1:0] fb_tgt;
  logic [GainBits-1:0] mix_tgt;

  fdl_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .fb_tgt_o  (fb_tgt),
    .mix_tgt_o (mix_tgt)
  );

  fdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fdl_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .fb_tgt_i     (fb_tgt),
    .mix_tgt_i    (mix_tgt),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o)
  );

endmodule

`default_nettype wire

// File: hdl/fdl_checker.sv
// port-level checks for the feedback delay line, bound to the top level
`default_nettype none

module fdl_checker
  import fdl_pkg::*;
(
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic signed [SampleBits-1:0] sample_out_o,
  input wire logic                         psel,
  input wire logic                         pwrite,
  input wire logic        [PaddrBits-1:0]  paddr,
  input wire logic        [PdataBits-1:0]  prdata
);

  // a stalled output word stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // a stalled output word holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sample_out_o))
    else $error("output word changed while stalled");

  // a word occupies the sequencer for its whole pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##7 !in_ready_o)
    else $error("input taken before the previous word finished");

  // feedback target never reads back above the loop-gain limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && paddr == PaddrBits'(0) |-> prdata <= PdataBits'(FbMax))
    else $error("feedback target above limit");

endmodule

bind feedback_delay_line fdl_checker u_fdl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .psel         (psel),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .prdata       (prdata)
);

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the feedback delay echo, with a bit-true echo predictor
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SmpW    = fdl_pkg::SampleBits;
  localparam int AddrW   = fdl_pkg::PaddrBits;
  localparam int DataW   = fdl_pkg::PdataBits;

  // echo geometry and gain constants
  localparam int LineDepth = 4096;
  localparam int PtrW      = 12;
  localparam int EchoDelay = 2400;
  localparam logic [15:0] FbCeil   = 16'd55705;
  localparam logic [15:0] FbStart  = 16'd22938;
  localparam logic [15:0] MixStart = 16'd26214;
  localparam longint SmoothCoef = 64'sd33554;
  localparam longint UnityQ24   = 64'sd16777216;
  localparam longint HalfLsb    = 64'sd8388608;
  localparam longint SmpMax     = 64'sd8388607;
  localparam longint SmpMin     = -64'sd8388608;

  localparam int PhaseWords = 116;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_EVERY4,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  typedef struct packed {
    logic signed [SmpW-1:0] sample;
    logic                   pinned;
    logic signed [SmpW-1:0] want;
  } dir_row_t;

  // directed words; the line is empty here, so a silent input must give silence
  localparam int DirRows = 18;
  localparam dir_row_t DirTable [DirRows] = '{
    '{24'sh000000, 1'b1, 24'sh000000},
    '{24'sh7FFFFF, 1'b0, 24'sh000000},
    '{24'sh800000, 1'b0, 24'sh000000},
    '{24'sh000000, 1'b1, 24'sh000000},
    '{24'shFFFFFF, 1'b0, 24'sh000000},
    '{24'sh000001, 1'b0, 24'sh000000},
    '{24'sh555555, 1'b0, 24'sh000000},
    '{24'shAAAAAA, 1'b0, 24'sh000000},
    '{24'sh800001, 1'b0, 24'sh000000},
    '{24'sh7FFFFE, 1'b0, 24'sh000000},
    '{24'sh400000, 1'b0, 24'sh000000},
    '{24'shC00000, 1'b0, 24'sh000000},
    '{24'sh000000, 1'b1, 24'sh000000},
    '{24'sh000002, 1'b0, 24'sh000000},
    '{24'shFFFFFE, 1'b0, 24'sh000000},
    '{24'sh0F0F0F, 1'b0, 24'sh000000},
    '{24'shF0F0F0, 1'b0, 24'sh000000},
    '{24'sh000000, 1'b1, 24'sh000000}
  };

  // dut signals; the driven inputs are known from time zero
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic signed [SmpW-1:0] sample_in_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [SmpW-1:0] sample_out_o;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [AddrW-1:0]       paddr       = '0;
  logic [DataW-1:0]       pwdata      = '0;
  logic [DataW-1:0]       prdata;
  logic                   pready;

  // pinned expectation travels with the driven word
  logic                   pin_q       = 1'b0;
  logic signed [SmpW-1:0] pin_val_q   = '0;

  // echo predictor state
  logic signed [SmpW-1:0] line_mem [LineDepth];
  logic [PtrW-1:0]        wr_ptr;
  logic [23:0]            fb_smooth;
  logic [23:0]            mix_smooth;
  logic [15:0]            fb_target;
  logic [15:0]            mix_target;

  logic signed [SmpW-1:0] echo_out_q [$];
  int unsigned            errors     = 0;
  int unsigned            burst_left = 0;

  rx_mode_e               rx_mode = RX_OPEN;
  int unsigned            rx_left = 0;
  logic [7:0]             rx_tick = '0;

  feedback_delay_line u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  // divide by 2^24, half away from zero
  function automatic longint round_q24(input longint v);
    if (v >= 0) begin
      return (v + HalfLsb) >>> 24;
    end
    return -((-v + HalfLsb) >>> 24);
  endfunction

  function automatic longint clip_sample(input longint v);
    if (v > SmpMax) begin
      return SmpMax;
    end else if (v < SmpMin) begin
      return SmpMin;
    end
    return v;
  endfunction

  // one-pole step of a Q0.24 gain toward its Q0.16 target
  function automatic logic [23:0] smooth_toward(input logic [23:0] cur, input logic [15:0] tgt);
    longint diff;
    longint nxt;
    diff = longint'({tgt, 8'h00}) - longint'(cur);
    nxt  = longint'(cur) + round_q24(diff * SmoothCoef);
    if (nxt < 0) begin
      nxt = 0;
    end else if (nxt > 64'sh00FF_FFFF) begin
      nxt = 64'sh00FF_FFFF;
    end
    return nxt[23:0];
  endfunction

  // advance the echo by one dry word and return the blended word
  function automatic logic signed [SmpW-1:0] echo_next(input logic signed [SmpW-1:0] dry_w);
    logic [PtrW-1:0] rd_ptr;
    longint          dry;
    longint          dly;
    longint          wet;
    longint          mix;
    longint          blend;
    fb_smooth  = smooth_toward(fb_smooth, fb_target);
    mix_smooth = smooth_toward(mix_smooth, mix_target);
    rd_ptr = wr_ptr - PtrW'(EchoDelay % LineDepth);
    dry    = dry_w;
    dly    = line_mem[rd_ptr];
    wet    = clip_sample(dry + round_q24(dly * longint'(fb_smooth)));
    line_mem[wr_ptr] = wet[SmpW-1:0];
    wr_ptr = wr_ptr + 1'b1;
    mix    = longint'(mix_smooth);
    blend  = clip_sample(round_q24(dry * (UnityQ24 - mix) + dly * mix));
    return blend[SmpW-1:0];
  endfunction

  // register write as the block stores it
  function automatic void set_target(input fdl_pkg::reg_idx_e idx, input logic [DataW-1:0] val);
    case (idx)
      fdl_pkg::REG_FEEDBACK: begin
        fb_target = (val[15:0] > FbCeil) ? FbCeil : val[15:0];
      end
      fdl_pkg::REG_MIX: begin
        mix_target = val[15:0];
      end
      default: begin
      end
    endcase
  endfunction

  // random dry word: extremes, quiet words, full-range noise, or loud positive
  function automatic logic signed [SmpW-1:0] draw_sample(input bit loud);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (loud && pick > 1) begin
      return SmpW'($urandom_range(24'h600000, 24'h7FFFFF));
    end
    case (pick)
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2, 3: return SmpW'(int'($urandom_range(0, 511)) - 256);
      default: return SmpW'($urandom());
    endcase
  endfunction

  // apb write: setup, then access until pready
  task automatic reg_write(input fdl_pkg::reg_idx_e idx, input logic [DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_target(idx, val);
  endtask

  // offer one input word, in bursts with random gaps
  task automatic send_word(input logic signed [SmpW-1:0] s, input logic pin,
                           input logic signed [SmpW-1:0] pv);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left  = burst_left - 1;
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    pin_q       <= pin;
    pin_val_q   <= pv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop offering and let every expected word drain
  task automatic drain_words();
    in_valid_i <= 1'b0;
    pin_q      <= 1'b0;
    while (echo_out_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic run_phase(input bit loud);
    for (int n = 0; n < PhaseWords; n++) begin
      send_word(draw_sample(loud), 1'b0, '0);
    end
    drain_words();
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(32, 255);
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_tick <= rx_tick + 1'b1;
      case (rx_mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_EVERY4: out_ready_i <= (rx_tick[1:0] == 2'd0);
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        default:   out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // predict on each accepted input word, compare each accepted output word
  always @(posedge clk_i) begin
    logic signed [SmpW-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (echo_out_q.size() == 0) begin
          errors++;
          $display("%0t: output word %0d with none expected", $time, sample_out_o);
        end else begin
          want = echo_out_q.pop_front();
          if (sample_out_o !== want) begin
            errors++;
            $display("%0t: sample_out expected %0d got %0d", $time, want, sample_out_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = echo_next(sample_in_i);
        if (pin_q) begin
          want = pin_val_q;
        end
        echo_out_q.push_back(want);
      end
    end
  end

  // main sequence
  initial begin
    for (int i = 0; i < LineDepth; i++) begin
      line_mem[i] = '0;
    end
    wr_ptr     = '0;
    fb_target  = FbStart;
    mix_target = MixStart;
    fb_smooth  = {FbStart, 8'h00};
    mix_smooth = {MixStart, 8'h00};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under reset gains
    for (int r = 0; r < DirRows; r++) begin
      send_word(DirTable[r].sample, DirTable[r].pinned, DirTable[r].want);
    end
    drain_words();

    // feedback above ceiling, full wet, junk in upper bits; loud input drives saturation
    reg_write(fdl_pkg::REG_FEEDBACK, 32'hFFFF_FFFF);
    reg_write(fdl_pkg::REG_MIX, 32'hABCD_FFFF);
    run_phase(1'b1);

    // all dry, no feedback
    reg_write(fdl_pkg::REG_FEEDBACK, 32'h0000_0000);
    reg_write(fdl_pkg::REG_MIX, 32'h0000_0000);
    run_phase(1'b0);

    // feedback at its ceiling, half mix
    reg_write(fdl_pkg::REG_FEEDBACK, {16'h5A5A, FbCeil});
    reg_write(fdl_pkg::REG_MIX, 32'h0000_8000);
    run_phase(1'b0);

    // random gains with random upper bits
    reg_write(fdl_pkg::REG_FEEDBACK, $urandom());
    reg_write(fdl_pkg::REG_MIX, $urandom());
    run_phase(1'b0);

    // just over the feedback ceiling, barely wet
    reg_write(fdl_pkg::REG_FEEDBACK, 32'h0000_D99A);
    reg_write(fdl_pkg::REG_MIX, 32'h0000_0001);
    run_phase(1'b1);

    if (errors == 0) begin
      $display("feedback_delay_line verification clean");
    end else begin
      $display("feedback_delay_line verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("feedback_delay_line verification failed");
    $finish;
  end

endmodule

`default_nettype wire
